/* src/pcaf_pkg.sv */
package pcaf_pkg;

    localparam int FRACTION_BITS     = 12;
    localparam int PHASE_TABLE_DEPTH = 1664;
    localparam int PH_W              = $clog2(PHASE_TABLE_DEPTH);
    localparam int SC_W              = FRACTION_BITS + 2;
    localparam int LS_AW_MAX         = 11;
    localparam int X_W               = 11;
    localparam int POS_W             = 12;
    localparam int POS_MAX           = 4094;
    localparam int LSP_W             = 10;
    localparam int LINE_PHASE_STEP   = 192;
    localparam int LINE_PHASE_MOD    = 832;
    localparam longint FX_SCALE      = 1000000;
    localparam longint FX_HALF       = 500000;

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ANG_MUL     = 64'd2784312575;
    localparam longint unsigned ANG_DIV     = 64'd1600000000;

    typedef logic signed [SC_W-1:0] sc_rom_t [PHASE_TABLE_DEPTH];

    // one pixel as classified by the front
    typedef struct packed {
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic                 bank;
        logic                 first;
        logic [PH_W-1:0]      ph;
        logic [1:0]           slot;
        logic [LS_AW_MAX-1:0] addr;
    } front_item_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MIX,
        BK_MOD1,
        BK_MOD2,
        BK_IIR1,
        BK_IIR2,
        BK_SIG,
        BK_DEM,
        BK_SUM,
        BK_LINE,
        BK_CONV,
        BK_OUT
    } back_state_t;

    function automatic logic signed [31:0] fx(longint micro);
        longint t;
        t = (micro * (longint'(1) <<< FRACTION_BITS) + FX_HALF) / FX_SCALE;
        return 32'(t);
    endfunction

    localparam logic signed [31:0] KY_R  = fx(299000);
    localparam logic signed [31:0] KY_G  = fx(587000);
    localparam logic signed [31:0] KY_B  = fx(114000);
    localparam logic signed [31:0] KU_R  = fx(147000);
    localparam logic signed [31:0] KU_G  = fx(289000);
    localparam logic signed [31:0] KU_B  = fx(436000);
    localparam logic signed [31:0] KV_R  = fx(615000);
    localparam logic signed [31:0] KV_G  = fx(515000);
    localparam logic signed [31:0] KV_B  = fx(100000);
    localparam logic signed [31:0] KF_A  = fx(754226);
    localparam logic signed [31:0] KF_B1 = fx(184815);
    localparam logic signed [31:0] KF_B2 = fx(332316);
    localparam logic signed [31:0] KO_RV = fx(142500);
    localparam logic signed [31:0] KO_GU = fx(49500);
    localparam logic signed [31:0] KO_GV = fx(72625);
    localparam logic signed [31:0] KO_BU = fx(253625);

    // fixed point product, floor shift, wrapped to 32 bits
    function automatic logic signed [31:0] fmul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[FRACTION_BITS+31:FRACTION_BITS];
    endfunction

    function automatic logic [7:0] clamp8(logic signed [31:0] v);
        logic signed [31:0] t;
        t = v >>> FRACTION_BITS;
        if (t < 0)
            return 8'd0;
        else if (t > 32'sd255)
            return 8'd255;
        else
            return t[7:0];
    endfunction

    // q30 taylor sine, rounded to the fraction width
    function automatic logic signed [SC_W-1:0] sin_q(longint unsigned ang_in);
        longint unsigned ang;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        logic            neg;
        ang = ang_in;
        neg = 1'b0;
        if (ang >= PI_Q30)
        begin
            ang = ang - PI_Q30;
            neg = 1'b1;
        end
        if (ang > HALF_PI_Q30)
            ang = PI_Q30 - ang;
        x    = ang;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            // divide by (2k)(2k+1)
            unique case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) <<< 30))
            sum = longint'(1) <<< 30;
        sum = (sum + (longint'(1) <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
        return neg ? SC_W'(-sum) : SC_W'(sum);
    endfunction

    function automatic sc_rom_t build_rom(logic want_cos);
        sc_rom_t         rom;
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        longint unsigned ang;
        for (int n = 0; n < PHASE_TABLE_DEPTH; n++)
        begin
            a   = longint'(n) * ANG_MUL;
            q   = a / ANG_DIV;
            r   = a % ANG_DIV;
            ang = ((q << 30) + ((r << 30) / ANG_DIV)) % TWO_PI_Q30;
            if (want_cos)
                rom[n] = sin_q((ang + HALF_PI_Q30) % TWO_PI_Q30);
            else
                rom[n] = sin_q(ang);
        end
        return rom;
    endfunction

endpackage

/* src/pal_composite_artifact_filter_top.sv */
// pal composite artifact filter: each rgb pixel request is encoded to a pal composite
// sample (smoothed luma plus chroma modulated on a rom subcarrier and band filtered by a
// second order iir) and decoded again through a four slot box demodulator and the pal
// delay line, giving one clamped rgb result per pixel. a front stage takes pixels, tracks
// subcarrier phase, column and line address, and queues them four deep; a back sequencer
// does the arithmetic one pixel at a time, in registered multiply steps and the iir
// feedback. a pixel flagged first of frame first clears both line store banks, one
// address a cycle; the same pass runs after reset, during which pixels still queue but
// no result comes out. x_start is written through cfg_we / cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
module pal_composite_artifact_filter_top
    import pcaf_pkg::*;
#(
    parameter int LINE_MAX = 1536
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: x_start
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    // pixel requests in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tlast,   // last_in_line
    input  logic [1:0]  s_tuser,   // line_parity, first_of_frame
    // decoded pixels out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_out, green_out, blue_out
);

    front_item_t f_item;
    front_item_t q_item;
    logic        f_push;
    logic        q_in_ready;
    logic        q_valid;
    logic        q_pop;
    logic [7:0]  red_o, green_o, blue_o;

    // front: phase, column and line address bookkeeping
    pcaf_front #(.LINE_MAX(LINE_MAX)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .red_in         (s_tdata[7:0]),
        .green_in       (s_tdata[15:8]),
        .blue_in        (s_tdata[23:16]),
        .line_parity    (s_tuser[0]),
        .last_in_line   (s_tlast),
        .first_of_frame (s_tuser[1]),
        .push           (f_push),
        .q_ready        (q_in_ready),
        .item           (f_item)
    );

    // short queue decoupling intake from the sequencer
    pcaf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .in_ready  (q_in_ready),
        .in_item   (f_item),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_item  (q_item)
    );

    // back: encode, filter, demodulate, delay line, convert
    pcaf_back #(.LINE_MAX(LINE_MAX)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red_out   (red_o),
        .green_out (green_o),
        .blue_out  (blue_o)
    );

    assign m_tdata = {blue_o, green_o, red_o};

endmodule

/* src/pcaf_front.sv */
module pcaf_front
    import pcaf_pkg::*;
#(
    parameter int LINE_MAX = 1536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [X_W-1:0]    cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  logic              line_parity,
    input  logic              last_in_line,
    input  logic              first_of_frame,
    output logic              push,
    input  logic              q_ready,
    output front_item_t       item
);

    localparam int QMAX    = POS_MAX / LINE_MAX;
    localparam int Q_STEPS = (QMAX < 1) ? 1 : $clog2(QMAX + 1);

    logic [X_W-1:0]   x_start_reg;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [LSP_W-1:0] lsp_reg, lsp_next;
    logic [X_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   rem;
    logic [PH_W:0]    ph_inc;
    logic [LSP_W:0]   lsp_sum;

    assign in_ready = q_ready;
    assign push     = in_valid & q_ready;
    assign pos      = POS_W'(x_start_reg) + POS_W'(col_reg);

    // line address: restoring remainder, one bit of quotient a step
    always_comb
    begin
        rem = {1'b0, pos};
        for (int k = Q_STEPS - 1; k >= 0; k--)
        begin
            if (rem >= (POS_W+1)'(LINE_MAX << k))
                rem = rem - (POS_W+1)'(LINE_MAX << k);
        end
    end

    always_comb
    begin
        item.red   = red_in;
        item.green = green_in;
        item.blue  = blue_in;
        item.bank  = line_parity;
        item.first = first_of_frame;
        item.ph    = phase_reg;
        item.slot  = pos[1:0];
        item.addr  = rem[LS_AW_MAX-1:0];
    end

    always_comb
    begin
        ph_inc  = {1'b0, phase_reg} + 1'b1;
        lsp_sum = {1'b0, lsp_reg} + (LSP_W+1)'(LINE_PHASE_STEP);
        if (ph_inc == (PH_W+1)'(PHASE_TABLE_DEPTH))
            phase_next = '0;
        else
            phase_next = ph_inc[PH_W-1:0];
        col_next = col_reg + 1'b1;
        lsp_next = lsp_reg;
        if (last_in_line)
        begin
            if (lsp_sum >= (LSP_W+1)'(LINE_PHASE_MOD))
                lsp_next = LSP_W'(lsp_sum - (LSP_W+1)'(LINE_PHASE_MOD));
            else
                lsp_next = lsp_sum[LSP_W-1:0];
            phase_next = PH_W'(lsp_next);
            col_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg <= '0;
            phase_reg   <= '0;
            lsp_reg     <= '0;
            col_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                x_start_reg <= cfg_wdata;
            if (push)
            begin
                phase_reg <= phase_next;
                lsp_reg   <= lsp_next;
                col_reg   <= col_next;
            end
        end
    end

endmodule

/* src/pcaf_queue.sv */
module pcaf_queue
    import pcaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        in_ready,
    input  front_item_t in_item,
    input  logic        pop,
    output logic        out_valid,
    output front_item_t out_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    front_item_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign in_ready  = (cnt_reg != (PW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* src/pcaf_back.sv */
module pcaf_back
    import pcaf_pkg::*;
#(
    parameter int LINE_MAX = 1536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  front_item_t q_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    localparam int AW = $clog2(LINE_MAX);
    localparam sc_rom_t SIN_ROM = build_rom(1'b0);
    localparam sc_rom_t COS_ROM = build_rom(1'b1);

    back_state_t state_reg, state_next;
    logic        run_reg, run_next;
    logic [AW-1:0] clr_cnt_reg;
    logic        clr_last;
    logic        load_out;
    logic        we0, we1;
    logic [AW-1:0] wr_addr;
    logic [63:0] wr_data;

    front_item_t item_reg;
    logic [63:0] bank0_mem [LINE_MAX];
    logic [63:0] bank1_mem [LINE_MAX];
    logic [63:0] rd0_reg, rd1_reg;
    logic signed [SC_W-1:0] sin_reg, cos_reg;
    logic signed [31:0] s32, c32;

    logic signed [31:0] la_reg, ih0_reg, ih1_reg, oh0_reg, oh1_reg;
    logic signed [31:0] win_u_reg [4];
    logic signed [31:0] win_v_reg [4];
    logic signed [31:0] y_reg, u_reg, v_reg, p1_reg, p2_reg, mod_reg;
    logic signed [31:0] m1_reg, m2_reg, m3_reg, m4_reg, sig_reg;
    logic signed [31:0] us_reg, vs_reg, tu_reg, tv_reg;
    logic signed [31:0] cr_reg, cgu_reg, cgv_reg, cb_reg;
    logic signed [31:0] r32, g32, b32, luma, u_c, v_c, y0;
    logic signed [32:0] la_sum;
    logic [63:0]        rd_other;
    logic               out_valid_reg;
    logic [7:0]         red_reg, green_reg, blue_reg;

    assign clr_last = (clr_cnt_reg == AW'(LINE_MAX - 1));
    assign s32      = 32'(sin_reg);
    assign c32      = 32'(cos_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = run_reg ? BK_MIX : BK_IDLE;
                    run_next   = 1'b0;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.first ? BK_CLEAR : BK_MIX;
                    run_next   = q_item.first;
                end
            end
            BK_MIX:  state_next = BK_MOD1;
            BK_MOD1: state_next = BK_MOD2;
            BK_MOD2: state_next = BK_IIR1;
            BK_IIR1: state_next = BK_IIR2;
            BK_IIR2: state_next = BK_SIG;
            BK_SIG:  state_next = BK_DEM;
            BK_DEM:  state_next = BK_SUM;
            BK_SUM:  state_next = BK_LINE;
            BK_LINE: state_next = BK_CONV;
            BK_CONV: state_next = BK_OUT;
            BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        we0      = 1'b0;
        we1      = 1'b0;
        wr_addr  = item_reg.addr[AW-1:0];
        wr_data  = {vs_reg, us_reg};
        unique case (state_reg)
            BK_CLEAR:
            begin
                we0     = 1'b1;
                we1     = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            BK_IDLE: pop = q_valid;
            BK_LINE:
            begin
                we0 = !item_reg.bank;
                we1 = item_reg.bank;
            end
            BK_OUT:  load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            run_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            if (state_reg == BK_CLEAR)
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // line store banks and rom
    always_ff @(posedge clk)
    begin
        if (we0)
            bank0_mem[wr_addr] <= wr_data;
        if (we1)
            bank1_mem[wr_addr] <= wr_data;
        rd0_reg <= bank0_mem[item_reg.addr[AW-1:0]];
        rd1_reg <= bank1_mem[item_reg.addr[AW-1:0]];
        sin_reg <= SIN_ROM[item_reg.ph];
        cos_reg <= COS_ROM[item_reg.ph];
    end

    always_comb
    begin
        r32    = {24'd0, item_reg.red};
        g32    = {24'd0, item_reg.green};
        b32    = {24'd0, item_reg.blue};
        luma   = KY_R * r32 + KY_G * g32 + KY_B * b32;
        u_c    = KU_B * b32 - KU_R * r32 - KU_G * g32;
        v_c    = KV_R * r32 - KV_G * g32 - KV_B * b32;
        la_sum = {la_reg[31], la_reg} + {luma[31], luma};
        y0     = m1_reg - m2_reg - m3_reg - m4_reg;
        rd_other = item_reg.bank ? rd0_reg : rd1_reg;
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg  <= '0;
            ih0_reg <= '0;
            ih1_reg <= '0;
            oh0_reg <= '0;
            oh1_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                win_u_reg[i] <= '0;
                win_v_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop && q_item.first)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    win_u_reg[i] <= '0;
                    win_v_reg[i] <= '0;
                end
            end
            if (state_reg == BK_MIX)
                la_reg <= la_sum[32:1];
            if (state_reg == BK_IIR2)
            begin
                ih1_reg <= ih0_reg;
                ih0_reg <= mod_reg;
                oh1_reg <= oh0_reg;
                oh0_reg <= y0;
            end
            if (state_reg == BK_DEM)
            begin
                win_u_reg[item_reg.slot] <= fmul(sig_reg, s32);
                win_v_reg[item_reg.slot] <= fmul(sig_reg, c32);
            end
        end
    end

    // per pixel datapath
    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_item;
        unique case (state_reg)
            BK_MIX:
            begin
                y_reg <= la_sum[32:1];
                u_reg <= u_c;
                v_reg <= v_c;
            end
            BK_MOD1:
            begin
                p1_reg <= fmul(u_reg, s32);
                p2_reg <= fmul(v_reg, c32);
            end
            BK_MOD2: mod_reg <= p1_reg + p2_reg;
            BK_IIR1:
            begin
                m1_reg <= fmul(KF_A, mod_reg);
                m2_reg <= fmul(KF_B1, oh0_reg);
                m3_reg <= fmul(KF_A, ih1_reg);
                m4_reg <= fmul(KF_B2, oh1_reg);
            end
            BK_SIG: sig_reg <= y_reg + oh0_reg;
            BK_SUM:
            begin
                us_reg <= win_u_reg[0] + win_u_reg[1] + win_u_reg[2] + win_u_reg[3];
                vs_reg <= win_v_reg[0] + win_v_reg[1] + win_v_reg[2] + win_v_reg[3];
            end
            BK_LINE:
            begin
                tu_reg <= us_reg + $signed(rd_other[31:0]);
                tv_reg <= vs_reg + $signed(rd_other[63:32]);
            end
            BK_CONV:
            begin
                cr_reg  <= fmul(KO_RV, tv_reg);
                cgu_reg <= fmul(KO_GU, tu_reg);
                cgv_reg <= fmul(KO_GV, tv_reg);
                cb_reg  <= fmul(KO_BU, tu_reg);
            end
            default: ;
        endcase
        if (load_out)
        begin
            red_reg   <= clamp8(y_reg + cr_reg);
            green_reg <= clamp8(y_reg - cgu_reg - cgv_reg);
            blue_reg  <= clamp8(y_reg + cb_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an unread result");

    a_dual_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (we0 && we1) |-> (state_reg == BK_CLEAR))
        else $error("both banks written outside the clearing pass");

    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CLEAR && !clr_last) |=> (state_reg == BK_CLEAR))
        else $error("clearing pass left early");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == BK_CLEAR || state_reg == BK_MIX))
        else $error("pixel taken without starting work");

endmodule

/* verif/pcaf_checker.sv */
`timescale 1ns / 1ps

module pcaf_checker
    import pcaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    localparam int LINE_LEN = 1536;

    // own sine and cosine tables, q30 taylor series
    longint sin_tab [PHASE_TABLE_DEPTH];
    longint cos_tab [PHASE_TABLE_DEPTH];

    logic [10:0] x_start_q;
    longint      luma_avg;
    longint      chroma_in [2];
    longint      chroma_out [2];
    longint      box_u [4];
    longint      box_v [4];
    longint      store_u [2*LINE_LEN];
    longint      store_v [2*LINE_LEN];
    int unsigned carrier_ph;
    int unsigned line_ph;
    int unsigned column;

    logic [23:0] decoded_q [$];

    function automatic longint wrap32(longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return wrap32((a * b) >>> FRACTION_BITS);
    endfunction

    function automatic longint coef(longint micro);
        return (micro * 4096 + 500000) / 1000000;
    endfunction

    function automatic longint taylor_sin(longint unsigned ang);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        bit              neg;
        neg = 0;
        if (ang >= PI_Q30)
        begin
            ang = ang - PI_Q30;
            neg = 1;
        end
        if (ang > HALF_PI_Q30)
            ang = PI_Q30 - ang;
        x = ang;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 8; k++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        sum = (sum + (longint'(1) << (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
        return neg ? -sum : sum;
    endfunction

    function automatic logic [7:0] sat8(longint v);
        longint t;
        t = v >>> FRACTION_BITS;
        if (t < 0)
            return 8'd0;
        if (t > 255)
            return 8'd255;
        return t[7:0];
    endfunction

    initial
    begin
        longint unsigned a;
        longint unsigned ang;
        for (int n = 0; n < PHASE_TABLE_DEPTH; n++)
        begin
            a = longint'(n) * ANG_MUL;
            ang = (((a / ANG_DIV) << 30) + (((a % ANG_DIV) << 30) / ANG_DIV)) % TWO_PI_Q30;
            sin_tab[n] = taylor_sin(ang);
            cos_tab[n] = taylor_sin((ang + HALF_PI_Q30) % TWO_PI_Q30);
        end
    end

    // encode and decode one pixel, returns packed rgb
    function automatic logic [23:0] decode_pixel(logic [23:0] rgb, logic [1:0] flags,
                                                 logic eol);
        longint r, g, b, luma, u, v, s, c, md, y0, sig, us, vs;
        int unsigned pos, slot, addr, bank;
        logic [7:0] ro, go, bo;
        r = rgb[7:0];
        g = rgb[15:8];
        b = rgb[23:16];
        bank = flags[0];
        if (flags[1])
        begin
            foreach (store_u[i])
            begin
                store_u[i] = 0;
                store_v[i] = 0;
            end
            foreach (box_u[i])
            begin
                box_u[i] = 0;
                box_v[i] = 0;
            end
        end
        luma = coef(299000) * r + coef(587000) * g + coef(114000) * b;
        u = -coef(147000) * r - coef(289000) * g + coef(436000) * b;
        v = coef(615000) * r - coef(515000) * g - coef(100000) * b;
        luma_avg = wrap32((luma_avg + luma) >>> 1);
        s = sin_tab[carrier_ph];
        c = cos_tab[carrier_ph];
        md = wrap32(fxmul(u, s) + fxmul(v, c));
        y0 = wrap32(fxmul(coef(754226), md) - fxmul(coef(184815), chroma_out[0])
                    - fxmul(coef(754226), chroma_in[1]) - fxmul(coef(332316), chroma_out[1]));
        chroma_in[1] = chroma_in[0];
        chroma_in[0] = md;
        chroma_out[1] = chroma_out[0];
        chroma_out[0] = y0;
        sig = wrap32(luma_avg + y0);
        pos = x_start_q + column;
        slot = pos & 3;
        box_u[slot] = fxmul(sig, s);
        box_v[slot] = fxmul(sig, c);
        us = wrap32(box_u[0] + box_u[1] + box_u[2] + box_u[3]);
        vs = wrap32(box_v[0] + box_v[1] + box_v[2] + box_v[3]);
        addr = pos % LINE_LEN;
        store_u[bank*LINE_LEN + addr] = us;
        store_v[bank*LINE_LEN + addr] = vs;
        us = wrap32(us + store_u[(bank^1)*LINE_LEN + addr]);
        vs = wrap32(vs + store_v[(bank^1)*LINE_LEN + addr]);
        ro = sat8(wrap32(luma_avg + fxmul(coef(142500), vs)));
        go = sat8(wrap32(luma_avg - fxmul(coef(49500), us) - fxmul(coef(72625), vs)));
        bo = sat8(wrap32(luma_avg + fxmul(coef(253625), us)));
        carrier_ph = (carrier_ph + 1) % PHASE_TABLE_DEPTH;
        column = (column + 1) & 11'h7ff;
        if (eol)
        begin
            line_ph = (line_ph + LINE_PHASE_STEP) % LINE_PHASE_MOD;
            carrier_ph = line_ph;
            column = 0;
        end
        return {bo, go, ro};
    endfunction

    assign pending = decoded_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            x_start_q = 0;
            luma_avg = 0;
            chroma_in = '{0, 0};
            chroma_out = '{0, 0};
            box_u = '{0, 0, 0, 0};
            box_v = '{0, 0, 0, 0};
            foreach (store_u[i])
            begin
                store_u[i] = 0;
                store_v[i] = 0;
            end
            carrier_ph = 0;
            line_ph = 0;
            column = 0;
            fail_count = 0;
            decoded_q.delete();
        end
        else
        begin
            if (cfg_we)
                x_start_q = cfg_wdata;
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_pixel(s_tdata, s_tuser, s_tlast));
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (want[7:0] !== m_tdata[7:0])
                    begin
                        $error("red_out expected %0d actual %0d", want[7:0], m_tdata[7:0]);
                        fail_count++;
                    end
                    if (want[15:8] !== m_tdata[15:8])
                    begin
                        $error("green_out expected %0d actual %0d", want[15:8], m_tdata[15:8]);
                        fail_count++;
                    end
                    if (want[23:16] !== m_tdata[23:16])
                    begin
                        $error("blue_out expected %0d actual %0d", want[23:16], m_tdata[23:16]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    longint      cycle_count;
    bit          hold_off;     // long receiver stall requested by stimulus
    bit          stall_active;

    // slowest pixel: a full back pass plus a clear of all 1536 line store addresses
    localparam longint CYCLE_LIMIT = 4000000;

    pal_composite_artifact_filter_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pcaf_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // watchdog, the only exit on a hang
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: random stall pattern, with stall-free stretches and a long hold-off
    initial
    begin
        int mode;
        m_tready = 0;
        stall_active = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off && !stall_active)
            begin
                stall_active = 1;
                m_tready <= 0;
                repeat (400) @(posedge clk);
                stall_active = 0;
            end
            mode = (cycle_count / 300) % 3;
            if (mode == 0)
                m_tready <= 1;
            else if (mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    // one pixel request; keeps tvalid high when the next burst item follows directly
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic parity,
                              logic eol, logic sof);
        s_tvalid <= 1;
        s_tdata  <= {b, g, r};
        s_tlast  <= eol;
        s_tuser  <= {sof, parity};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            s_tvalid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // let all results drain, then allow the back end to settle before a register write
    task automatic drain_and_write(logic [10:0] value);
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // random lines of a frame; most pixels are well-formed lines with random content
    task automatic send_frame(int lines, int max_len);
        int len;
        for (int ln = 0; ln < lines; ln++)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, max_len)
                                               : $urandom_range(1, 24);
            for (int c = 0; c < len; c++)
            begin
                send_pixel($urandom, $urandom, $urandom, ln[0] ^ ($urandom_range(0, 9) == 0),
                           (c == len - 1), (ln == 0 && c == 0));
                gap();
            end
        end
    endtask

    initial
    begin
        logic [10:0] settings [5] = '{11'd0, 11'd1535, 11'd3, 11'd2047, 11'd770};
        rst_n     = 0;
        cfg_we    = 0;
        cfg_wdata = 0;
        s_tvalid  = 0;
        s_tdata   = 0;
        s_tlast   = 0;
        s_tuser   = 0;
        hold_off  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, frame start, line end, both at once
        send_pixel(8'd0, 8'd0, 8'd0, 0, 0, 1);
        send_pixel(8'd255, 8'd255, 8'd255, 0, 0, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 0, 0, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 0, 0, 0);
        send_pixel(8'd0, 8'd0, 8'd255, 0, 1, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 1, 0, 0);
        send_pixel(8'd0, 8'd255, 8'd255, 1, 0, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 1, 1, 0);
        send_pixel(8'd170, 8'd85, 8'd170, 0, 1, 1);
        send_pixel(8'd85, 8'd170, 8'd85, 1, 0, 0);
        send_pixel(8'd255, 8'd255, 8'd0, 1, 1, 0);
        for (int i = 0; i < 6; i++)
            send_pixel(8'd255, 8'd0, 8'd255, i[0], 0, 0);

        // long line: column past the store length and phase table wrap
        // (line starts near phase 774, so the table wraps after about 890 pixels)
        drain_and_write(11'd1400);
        for (int c = 0; c < 920; c++)
        begin
            send_pixel($urandom, $urandom, $urandom, 0, (c == 919), 0);
            if ($urandom_range(0, 7) == 0)
                gap();
        end

        // random part across register settings, long receiver hold-off in the middle
        foreach (settings[k])
        begin
            drain_and_write(settings[k]);
            if (k == 2)
                hold_off = 1;
            send_frame(3, 60);
            hold_off = 0;
            send_pixel($urandom, $urandom, $urandom, $urandom, $urandom, 0);
        end

        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
